@@ rtl/diamond_difference_flux_sweep_unit_defines.svh @@
// Assertion macros for the diamond-difference flux sweep unit.
// Included by the top level; needs nothing else.
`ifndef DIAMOND_DIFFERENCE_FLUX_SWEEP_UNIT_DEFINES_SVH
`define DIAMOND_DIFFERENCE_FLUX_SWEEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DDFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DDFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define DDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/ddfs_pkg.sv @@
// Shared widths, limits and handshake structs of the flux sweep unit.
// Used by the serial divider, the serial multiplier and the top level.
package ddfs_pkg;

  localparam int FRAC_BITS = 16;

  localparam int FLUX_W = 32;
  localparam int MU_W   = 18;
  localparam int LEN_W  = 31;

  localparam int DVD_W     = 64;
  localparam int DVS_W     = LEN_W + 1;
  localparam int QUO_W     = LEN_W + 2;
  localparam int DIV_CNT_W = 7;

  localparam int MUL_A_W   = FLUX_W;
  localparam int MUL_B_W   = LEN_W + 2;
  localparam int MUL_P_W   = 2 * MUL_B_W;
  localparam int MUL_CNT_W = 6;

  localparam int N_W   = DVD_W + 1 - FRAC_BITS;
  localparam int MAG_W = N_W - 1;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_A_STEPS = DIV_CNT_W'(MU_W + FRAC_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_N_STEPS = DIV_CNT_W'(DVD_W);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST    = MUL_CNT_W'(MUL_B_W - 1);

  localparam logic [QUO_W-1:0]  POS_LIM  = 33'h0_7FFF_FFFF;
  localparam logic [QUO_W-1:0]  NEG_LIM  = 33'h0_8000_0000;
  localparam logic [FLUX_W-1:0] FLUX_MAX = 32'h7FFF_FFFF;
  localparam logic [FLUX_W-1:0] FLUX_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                 go;
    logic [DVD_W-1:0]     dividend;
    logic [DVS_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic             over;
  } div_rsp_t;

  typedef struct packed {
    logic                      go;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [MUL_P_W-1:0] product;
  } mul_rsp_t;

endpackage

@@ rtl/ddfs_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ddfs_pkg for widths and the request and response structs.
module ddfs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ddfs_pkg::div_req_t req,
  output ddfs_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [ddfs_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [ddfs_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [ddfs_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [ddfs_pkg::QUO_W-1:0]     quo_r, quo_nxt;
  logic                           over_r, over_nxt;
  logic [ddfs_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ddfs_pkg::DVS_W:0]       trial;
  logic [ddfs_pkg::DVS_W:0]       diff;
  logic                           take;

  always_comb begin
    trial    = {rem_r, dvd_r[ddfs_pkg::DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    take     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    over_nxt = over_r;
    cnt_nxt  = cnt_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      over_nxt = 1'b0;
      cnt_nxt  = req.steps;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[ddfs_pkg::DVD_W-2:0], 1'b0};
      rem_nxt  = take ? diff[ddfs_pkg::DVS_W-1:0] : trial[ddfs_pkg::DVS_W-1:0];
      quo_nxt  = {quo_r[ddfs_pkg::QUO_W-2:0], take};
      over_nxt = over_r | quo_r[ddfs_pkg::QUO_W-1];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == ddfs_pkg::DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    over_r <= over_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.over     = over_r;

endmodule

@@ rtl/ddfs_mul.sv @@
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on ddfs_pkg for widths and the request and response structs.
module ddfs_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  ddfs_pkg::mul_req_t req,
  output ddfs_pkg::mul_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [ddfs_pkg::MUL_A_W-1:0]   a_r, a_nxt;
  logic [ddfs_pkg::MUL_B_W-1:0]   b_r, b_nxt;
  logic [ddfs_pkg::MUL_B_W-1:0]   hi_r, hi_nxt;
  logic [ddfs_pkg::MUL_B_W-1:0]   lo_r, lo_nxt;
  logic [ddfs_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ddfs_pkg::MUL_B_W:0]     ext_hi;
  logic [ddfs_pkg::MUL_B_W:0]     ext_a;
  logic [ddfs_pkg::MUL_B_W:0]     sum;
  logic                           last;

  always_comb begin
    ext_hi = {hi_r[ddfs_pkg::MUL_B_W-1], hi_r};
    ext_a  = {{(ddfs_pkg::MUL_B_W + 1 - ddfs_pkg::MUL_A_W){a_r[ddfs_pkg::MUL_A_W-1]}}, a_r};
    last   = cnt_r == ddfs_pkg::MUL_LAST;
    if (!b_r[0]) begin
      sum = ext_hi;
    end else if (last) begin
      sum = ext_hi - ext_a;
    end else begin
      sum = ext_hi + ext_a;
    end
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      a_nxt    = req.a;
      b_nxt    = req.b;
      hi_nxt   = '0;
      lo_nxt   = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      hi_nxt  = sum[ddfs_pkg::MUL_B_W:1];
      lo_nxt  = {sum[0], lo_r[ddfs_pkg::MUL_B_W-1:1]};
      b_nxt   = {1'b0, b_r[ddfs_pkg::MUL_B_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.busy    = busy_r;
  assign rsp.done    = done_r;
  assign rsp.product = {hi_r, lo_r};

endmodule

@@ rtl/diamond_difference_flux_sweep_unit.sv @@
// Top level of the diamond-difference slab sweep: sequencer, running flux, output register.
// Depends on ddfs_pkg, ddfs_div, ddfs_mul and the assertion macro header.
//
//   Channel  Handshake            Words carried
//   in_      in_valid / in_ready   one cell and the start flag with boundary flux
//   out_     out_valid / out_ready outgoing edge flux, ray end, saturation flag
//
// One cell passes from acceptance to result through two passes of the shared
// serial divider and two passes of the serial multiplier, with sequencing
// states between them. The next cell is accepted from the cycle after the
// result has moved into the output register; a result waiting for out_ready
// holds the sequencer until it moves.
// Reset clears the running flux to zero and empties the output register.
`include "diamond_difference_flux_sweep_unit_defines.svh"
module diamond_difference_flux_sweep_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_start_of_ray,
  input  logic signed [ddfs_pkg::FLUX_W-1:0]  in_boundary_flux,
  input  logic signed [ddfs_pkg::MU_W-1:0]    in_direction_cosine,
  input  logic        [ddfs_pkg::LEN_W-1:0]   in_cell_width,
  input  logic        [ddfs_pkg::LEN_W-1:0]   in_total_xs,
  input  logic signed [ddfs_pkg::FLUX_W-1:0]  in_scatter_iso,
  input  logic signed [ddfs_pkg::FLUX_W-1:0]  in_scatter_lin,
  input  logic signed [ddfs_pkg::FLUX_W-1:0]  in_ext_source,
  input  logic                                in_last_cell,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ddfs_pkg::FLUX_W-1:0]  out_edge_flux,
  output logic                                out_ray_end,
  output logic                                out_saturated
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_MUL_LIN,
    ST_MUL_NUM,
    ST_ADD_S0,
    ST_ADD_Q,
    ST_DIV_GO,
    ST_DIV_N,
    ST_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ddfs_pkg::FLUX_W-1:0]   psi_r, psi_nxt;
  logic [ddfs_pkg::MU_W-1:0]     mu_r, mu_nxt;
  logic [ddfs_pkg::LEN_W-1:0]    sig_r, sig_nxt;
  logic [ddfs_pkg::FLUX_W-1:0]   s0_r, s0_nxt;
  logic [ddfs_pkg::FLUX_W-1:0]   s1_r, s1_nxt;
  logic [ddfs_pkg::FLUX_W-1:0]   q_r, q_nxt;
  logic                          last_r, last_nxt;
  logic [ddfs_pkg::LEN_W-1:0]    a_r, a_nxt;
  logic [ddfs_pkg::N_W-1:0]      n_r, n_nxt;
  logic                          neg_r, neg_nxt;
  logic                          mag_zero_r, mag_zero_nxt;
  logic                          den_zero_r, den_zero_nxt;
  logic                          sat_r, sat_nxt;
  logic [ddfs_pkg::FLUX_W-1:0]   res_r, res_nxt;
  logic [ddfs_pkg::FLUX_W-1:0]   run_r, run_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ddfs_pkg::FLUX_W-1:0]   out_flux_r, out_flux_nxt;
  logic                          out_end_r, out_end_nxt;
  logic                          out_sat_r, out_sat_nxt;
  ddfs_pkg::div_req_t            div_req_r, div_req_nxt;
  ddfs_pkg::mul_req_t            mul_req_r, mul_req_nxt;
  ddfs_pkg::div_rsp_t            div_rsp;
  ddfs_pkg::mul_rsp_t            mul_rsp;

  logic [ddfs_pkg::MU_W-1:0]     amu_in;
  logic [ddfs_pkg::MU_W+1:0]     mu3;
  logic [ddfs_pkg::LEN_W-2:0]    half;
  logic [ddfs_pkg::MUL_B_W-1:0]  a_minus_half;
  logic [ddfs_pkg::DVS_W-1:0]    den;
  logic [ddfs_pkg::N_W-1:0]      mag;
  logic [ddfs_pkg::QUO_W-1:0]    limit;
  logic                          a_over;
  logic                          n_over;

  ddfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  ddfs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

  always_comb begin
    amu_in = in_direction_cosine[ddfs_pkg::MU_W-1] ? (~in_direction_cosine + 1'b1)
                                                    : in_direction_cosine;
    mu3 = {{2{mu_r[ddfs_pkg::MU_W-1]}}, mu_r} + {mu_r[ddfs_pkg::MU_W-1], mu_r, 1'b0};
    half = sig_r[ddfs_pkg::LEN_W-1:1];
    a_minus_half = {2'b00, a_r} - {3'b000, half};
    den = {1'b0, a_r} + {2'b00, half};
    mag = n_r[ddfs_pkg::N_W-1] ? (~n_r + 1'b1) : n_r;
    limit = neg_r ? ddfs_pkg::NEG_LIM : ddfs_pkg::POS_LIM;
    a_over = div_rsp.over || (div_rsp.quotient > ddfs_pkg::POS_LIM);
    n_over = div_rsp.over || (div_rsp.quotient > limit);

    state_nxt     = state_r;
    psi_nxt       = psi_r;
    mu_nxt        = mu_r;
    sig_nxt       = sig_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    q_nxt         = q_r;
    last_nxt      = last_r;
    a_nxt         = a_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    mag_zero_nxt  = mag_zero_r;
    den_zero_nxt  = den_zero_r;
    sat_nxt       = sat_r;
    res_nxt       = res_r;
    run_nxt       = run_r;
    out_valid_nxt = out_valid_r;
    out_flux_nxt  = out_flux_r;
    out_end_nxt   = out_end_r;
    out_sat_nxt   = out_sat_r;
    div_req_nxt    = div_req_r;
    div_req_nxt.go = 1'b0;
    mul_req_nxt    = mul_req_r;
    mul_req_nxt.go = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          psi_nxt  = in_start_of_ray ? in_boundary_flux : run_r;
          mu_nxt   = in_direction_cosine;
          sig_nxt  = in_total_xs;
          s0_nxt   = in_scatter_iso;
          s1_nxt   = in_scatter_lin;
          q_nxt    = in_ext_source;
          last_nxt = in_last_cell;
          sat_nxt  = 1'b0;
          div_req_nxt.go       = 1'b1;
          div_req_nxt.dividend = {amu_in, {(ddfs_pkg::DVD_W - ddfs_pkg::MU_W){1'b0}}};
          div_req_nxt.divisor  = {1'b0, in_cell_width};
          div_req_nxt.steps    = ddfs_pkg::DIV_A_STEPS;
          state_nxt = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (div_rsp.done) begin
          a_nxt   = a_over ? {ddfs_pkg::LEN_W{1'b1}} : div_rsp.quotient[ddfs_pkg::LEN_W-1:0];
          sat_nxt = sat_r | a_over;
          mul_req_nxt.go = 1'b1;
          mul_req_nxt.a  = s1_r;
          mul_req_nxt.b  = {{(ddfs_pkg::MUL_B_W - ddfs_pkg::MU_W - 2){mu3[ddfs_pkg::MU_W+1]}},
                            mu3};
          state_nxt = ST_MUL_LIN;
        end
      end
      ST_MUL_LIN: begin
        if (mul_rsp.done) begin
          n_nxt = mul_rsp.product[ddfs_pkg::FRAC_BITS+1 +: ddfs_pkg::N_W];
          mul_req_nxt.go = 1'b1;
          mul_req_nxt.a  = psi_r;
          mul_req_nxt.b  = a_minus_half;
          state_nxt = ST_MUL_NUM;
        end
      end
      ST_MUL_NUM: begin
        if (mul_rsp.done) begin
          n_nxt = n_r + mul_rsp.product[ddfs_pkg::FRAC_BITS +: ddfs_pkg::N_W];
          state_nxt = ST_ADD_S0;
        end
      end
      ST_ADD_S0: begin
        n_nxt = n_r + {{(ddfs_pkg::N_W - ddfs_pkg::FLUX_W){s0_r[ddfs_pkg::FLUX_W-1]}}, s0_r};
        state_nxt = ST_ADD_Q;
      end
      ST_ADD_Q: begin
        n_nxt = n_r + {{(ddfs_pkg::N_W - ddfs_pkg::FLUX_W){q_r[ddfs_pkg::FLUX_W-1]}}, q_r};
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        neg_nxt      = n_r[ddfs_pkg::N_W-1];
        mag_zero_nxt = n_r == '0;
        den_zero_nxt = den == '0;
        div_req_nxt.go       = 1'b1;
        div_req_nxt.dividend = {mag[ddfs_pkg::MAG_W-1:0], {ddfs_pkg::FRAC_BITS{1'b0}}};
        div_req_nxt.divisor  = den;
        div_req_nxt.steps    = ddfs_pkg::DIV_N_STEPS;
        state_nxt = ST_DIV_N;
      end
      ST_DIV_N: begin
        if (div_rsp.done) begin
          if (mag_zero_r) begin
            res_nxt = '0;
            sat_nxt = sat_r | den_zero_r;
          end else if (n_over) begin
            res_nxt = neg_r ? ddfs_pkg::FLUX_MIN : ddfs_pkg::FLUX_MAX;
            sat_nxt = 1'b1;
          end else if (neg_r) begin
            res_nxt = ~div_rsp.quotient[ddfs_pkg::FLUX_W-1:0] + 1'b1;
          end else begin
            res_nxt = div_rsp.quotient[ddfs_pkg::FLUX_W-1:0];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_flux_nxt  = res_r;
          out_end_nxt   = last_r;
          out_sat_nxt   = sat_r;
          run_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      run_r          <= '0;
      out_valid_r    <= 1'b0;
      div_req_r.go   <= 1'b0;
      mul_req_r.go   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      run_r          <= run_nxt;
      out_valid_r    <= out_valid_nxt;
      div_req_r.go   <= div_req_nxt.go;
      mul_req_r.go   <= mul_req_nxt.go;
    end
    psi_r                <= psi_nxt;
    mu_r                 <= mu_nxt;
    sig_r                <= sig_nxt;
    s0_r                 <= s0_nxt;
    s1_r                 <= s1_nxt;
    q_r                  <= q_nxt;
    last_r               <= last_nxt;
    a_r                  <= a_nxt;
    n_r                  <= n_nxt;
    neg_r                <= neg_nxt;
    mag_zero_r           <= mag_zero_nxt;
    den_zero_r           <= den_zero_nxt;
    sat_r                <= sat_nxt;
    res_r                <= res_nxt;
    out_flux_r           <= out_flux_nxt;
    out_end_r            <= out_end_nxt;
    out_sat_r            <= out_sat_nxt;
    div_req_r.dividend   <= div_req_nxt.dividend;
    div_req_r.divisor    <= div_req_nxt.divisor;
    div_req_r.steps      <= div_req_nxt.steps;
    mul_req_r.a          <= mul_req_nxt.a;
    mul_req_r.b          <= mul_req_nxt.b;
  end

  assign in_ready      = state_r == ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_edge_flux = out_flux_r;
  assign out_ray_end   = out_end_r;
  assign out_saturated = out_sat_r;

  `DDFS_ASSERT_IMPLY(a_units_exclusive, clk, rst_n, div_rsp.busy, !mul_rsp.busy, "divider and multiplier busy together")
  `DDFS_ASSERT_IMPLY(a_idle_units_free, clk, rst_n, in_ready, !div_rsp.busy && !mul_rsp.busy, "word accepted while an arithmetic unit is busy")
  `DDFS_ASSERT_IMPLY(a_out_from_done, clk, rst_n, $rose(out_valid), $past(state_r == ST_DONE), "result word appeared outside the hand-off state")
  `DDFS_ASSERT_NEXT(a_run_tracks_out, clk, rst_n, state_r == ST_DONE && (!out_valid_r || out_ready), run_r == out_edge_flux, "running flux differs from the delivered edge flux")

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the diamond-difference flux sweep unit: directed and random cells,
// predicted in Q16.16 here and compared with every result word. Depends on ddfs_pkg and the RTL.
module tb_top;
  import ddfs_pkg::*;

  localparam int N_ITEMS     = 900;
  localparam int IDLE_PCT    = 22;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct {
    logic                     start_of_ray;
    logic signed [FLUX_W-1:0] boundary_flux;
    logic signed [MU_W-1:0]   direction_cosine;
    logic [LEN_W-1:0]         cell_width;
    logic [LEN_W-1:0]         total_xs;
    logic signed [FLUX_W-1:0] scatter_iso;
    logic signed [FLUX_W-1:0] scatter_lin;
    logic signed [FLUX_W-1:0] ext_source;
    logic                     last_cell;
  } cell_t;

  typedef struct {
    logic signed [FLUX_W-1:0] edge_flux;
    logic                     ray_end;
    logic                     saturated;
  } edge_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_start_of_ray = 1'b0;
  logic signed [FLUX_W-1:0] in_boundary_flux = '0;
  logic signed [MU_W-1:0] in_direction_cosine = '0;
  logic [LEN_W-1:0] in_cell_width = '0;
  logic [LEN_W-1:0] in_total_xs = '0;
  logic signed [FLUX_W-1:0] in_scatter_iso = '0;
  logic signed [FLUX_W-1:0] in_scatter_lin = '0;
  logic signed [FLUX_W-1:0] in_ext_source = '0;
  logic in_last_cell = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FLUX_W-1:0] out_edge_flux;
  logic out_ray_end;
  logic out_saturated;

  cell_t cell_q[$];
  edge_t edge_q[$];
  cell_t cur_cell;
  edge_t want;
  logic signed [FLUX_W-1:0] sweep_flux = '0;
  int errors = 0;
  int cells_sent = 0;
  int stall_cnt = 0;
  logic calm;

  diamond_difference_flux_sweep_unit dut (.*);

  always #4 clk = ~clk;

  // No idling on either side while this band of cells goes through.
  assign calm = (cells_sent >= 400) && (cells_sent < 550);

  function automatic edge_t diamond_step(cell_t c);
    longint psi, mu, amu, h, sigma, a, half, num, lin, n, res;
    longint unsigned mag, lim, den, qi, rem, full;
    logic sat, ovf, neg;
    edge_t e;
    sat = 1'b0;
    ovf = 1'b0;
    psi = c.start_of_ray ? longint'(c.boundary_flux) : longint'(sweep_flux);
    mu = longint'(c.direction_cosine);
    amu = (mu < 0) ? -mu : mu;
    h = longint'(c.cell_width);
    sigma = longint'(c.total_xs);
    if (h == 0) begin
      a = longint'(FLUX_MAX);
      sat = 1'b1;
    end else begin
      a = (amu <<< FRAC_BITS) / h;
      if (a > longint'(FLUX_MAX)) begin
        a = longint'(FLUX_MAX);
        sat = 1'b1;
      end
    end
    half = sigma >>> 1;
    num = (psi * (a - half)) >>> FRAC_BITS;
    lin = (3 * longint'(c.scatter_lin) * mu) >>> (FRAC_BITS + 1);
    n = num + longint'(c.scatter_iso) + lin + longint'(c.ext_source);
    den = longint'(a + half);
    neg = (n < 0);
    mag = neg ? -n : n;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (den == 0) begin
      sat = 1'b1;
      res = (n > 0) ? longint'(FLUX_MAX) : ((n < 0) ? longint'($signed(FLUX_MIN)) : 0);
    end else begin
      qi = mag / den;
      rem = mag % den;
      full = 0;
      if (qi > (lim >> FRAC_BITS)) begin
        ovf = 1'b1;
      end else begin
        full = (qi << FRAC_BITS) + (rem << FRAC_BITS) / den;
        if (full > lim) ovf = 1'b1;
      end
      if (ovf) begin
        sat = 1'b1;
        res = neg ? longint'($signed(FLUX_MIN)) : longint'(FLUX_MAX);
      end else begin
        res = neg ? -longint'(full) : longint'(full);
      end
    end
    sweep_flux = res[FLUX_W-1:0];
    e.edge_flux = res[FLUX_W-1:0];
    e.ray_end = c.last_cell;
    e.saturated = sat;
    return e;
  endfunction

  task automatic push_cell(input logic st, input logic [31:0] bf, input logic [31:0] mu,
                           input logic [31:0] h, input logic [31:0] sig, input logic [31:0] s0,
                           input logic [31:0] s1, input logic [31:0] q, input logic last);
    cell_t c;
    c.start_of_ray = st;
    c.boundary_flux = bf;
    c.direction_cosine = mu[MU_W-1:0];
    c.cell_width = h[LEN_W-1:0];
    c.total_xs = sig[LEN_W-1:0];
    c.scatter_iso = s0;
    c.scatter_lin = s1;
    c.ext_source = q;
    c.last_cell = last;
    cell_q.push_back(c);
  endtask

  function automatic logic [31:0] spread(int unsigned r);
    return $urandom_range(0, 2 * r) - r;
  endfunction

  task automatic push_ray_cell(input logic first, input logic last);
    logic [31:0] mu, s0, q;
    mu = $urandom_range(0, 65536);
    if ($urandom_range(1)) mu = -mu;
    s0 = spread(32'h40000);
    q = spread(32'h40000);
    if ($urandom_range(19) == 0) s0 = $urandom;
    if ($urandom_range(19) == 0) q = $urandom;
    push_cell(first, spread(32'h40000), mu, $urandom_range(32'h800, 32'h40000),
              $urandom_range(0, 32'h60000), s0, spread(32'h40000), q, last);
  endtask

  // Driver: a new word goes out only once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        edge_q.push_back(diamond_step(cur_cell));
        cells_sent <= cells_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (cell_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_cell = cell_q.pop_front();
          in_start_of_ray <= cur_cell.start_of_ray;
          in_boundary_flux <= cur_cell.boundary_flux;
          in_direction_cosine <= cur_cell.direction_cosine;
          in_cell_width <= cur_cell.cell_width;
          in_total_xs <= cur_cell.total_xs;
          in_scatter_iso <= cur_cell.scatter_iso;
          in_scatter_lin <= cur_cell.scatter_lin;
          in_ext_source <= cur_cell.ext_source;
          in_last_cell <= cur_cell.last_cell;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (edge_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual flux %h ray_end %b sat %b",
                   $time, out_edge_flux, out_ray_end, out_saturated);
          errors++;
        end else begin
          want = edge_q.pop_front();
          if (out_edge_flux !== want.edge_flux) begin
            $display("%0t: edge_flux expected %h actual %h", $time, want.edge_flux,
                     out_edge_flux);
            errors++;
          end
          if (out_ray_end !== want.ray_end) begin
            $display("%0t: ray_end expected %b actual %b", $time, want.ray_end, out_ray_end);
            errors++;
          end
          if (out_saturated !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                     out_saturated);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("diamond_difference_flux_sweep_unit: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    int len;
    int n_total;
    push_cell(1, 32'h10000, 32'h8000, 32'h10000, 32'h10000, 32'h10000, 32'h8000, 32'h10000, 0);
    push_cell(0, 0, -32'sh8000, 32'h20000, 32'h4000, 32'h2000, -32'sh4000, 32'h1000, 1);
    push_cell(0, 0, 32'h4000, 32'h10000, 32'h8000, 32'h1000, 0, 32'h1000, 0);
    push_cell(1, 32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 0, 0, 0);
    push_cell(1, 32'h10000, 32'h10000, 1, 32'h10000, 32'h10000, 0, 0, 0);
    push_cell(1, 0, 0, 32'h10000, 1, 32'h10000, 0, 0, 0);
    push_cell(1, 0, 0, 32'h10000, 0, -32'sh10000, 0, 0, 0);
    push_cell(1, 0, 0, 32'h10000, 1, 0, 0, 0, 1);
    push_cell(1, 0, 32'h10000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 0);
    push_cell(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0);
    push_cell(1, 0, 32'h10000, 32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h80000000, 1);
    push_cell(1, 32'h10000, 32'h1FFFF, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0);
    push_cell(0, 0, 32'h20000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 1);
    push_cell(1, 32'h7FFFFFFF, -32'sh10000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    push_cell(1, 32'h80000000, 32'h10000, 1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 1);
    push_cell(1, 32'h80000000, 1, 32'h7FFFFFFF, 2, 32'h100, 0, 0, 1);
    push_cell(1, 0, 32'h10000, 32'h10000, 32'h10000, -32'sh1, 0, 0, 1);
    push_cell(1, 0, 32'h10000, 32'h10000, 32'h10000, -32'sh10001, 0, 0, 1);
    push_cell(1, 0, 32'h10000, 32'h10000, 0, 32'h80000000, 0, 0, 1);
    push_cell(1, 0, 32'h10000, 32'h10000, 0, 32'h80000000, 0, -32'sh1, 1);
    push_cell(1, 0, 32'h10000, 32'h10000, 0, 32'h7FFFFFFF, 0, 0, 1);
    push_cell(1, 32'hFFFFFFFF, 32'h3FFFF, 32'h55555555, 32'h2AAAAAAA, 32'hAAAAAAAA,
              32'h55555555, 32'hFFFFFFFF, 1);
    while (cell_q.size() < N_ITEMS) begin
      if ($urandom_range(99) < 12) begin
        push_cell($urandom_range(1) != 0, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom_range(1) != 0);
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) push_ray_cell(i == 0, i == len - 1);
      end
    end
    n_total = cell_q.size();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (cells_sent != n_total || edge_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && edge_q.size() == 0) begin
      $display("diamond_difference_flux_sweep_unit: match");
    end else begin
      $display("diamond_difference_flux_sweep_unit: mismatch");
    end
    $finish;
  end

endmodule
